// File: src/pwrs_pkg.sv
`timescale 1ns / 1ps
package pwrs_pkg;

	localparam int MAX_QUEUES_D   = 4;
	localparam int QUEUE_DEPTH_D  = 64;
	localparam int WEIGHT_BITS_D  = 8;
	localparam int RANDOM_BITS_D  = 16;

	localparam int HANDLE_W = 16;
	localparam int BYTES_W  = 16;
	localparam int PRIO_W   = 16;
	localparam int AHEAD_W  = 24;
	localparam int DESC_W   = HANDLE_W + BYTES_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int NQ_W     = 3;

	localparam logic [AHEAD_W-1:0] AHEAD_MAX = '1;

	typedef enum logic [1:0] {
		KIND_ENQ   = 2'd0,
		KIND_DEQ   = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DROP  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_NUM_QUEUES = 2'd0,
		CFG_WEIGHT_Q1  = 2'd1,
		CFG_WEIGHT_Q2  = 2'd2,
		CFG_WEIGHT_Q3  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input item, compute decision
		logic commit;    // apply enqueue bookkeeping, register result
		logic capture;   // latch result from RAM read data, apply pop bookkeeping
		logic out_take;  // result transferred
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_read; // the item pops a descriptor
	} sts_t;

endpackage

// File: src/priority_weighted_random_scheduler.sv
`timescale 1ns / 1ps
// Multi-queue descriptor scheduler. Enqueue (kind 0) appends a handle/bytes
// descriptor to the queue chosen by its tag; dequeue (kind 1) serves queue 0
// first, else a weighted random pick among non-empty lower queues; query
// (kind 2) returns queued bytes up to a priority. One item at a time: an
// enqueue or query result is registered in EXEC and valid in OUT; a dequeue
// that pops adds a READ state, set by the registered read of the descriptor
// memory. The next item is taken once the result is transferred.
// Configuration writes only while idle; num_queues is ignored while any
// queue holds a descriptor.
module priority_weighted_random_scheduler #(
	parameter int MAX_QUEUES  = pwrs_pkg::MAX_QUEUES_D,
	parameter int QUEUE_DEPTH = pwrs_pkg::QUEUE_DEPTH_D,
	parameter int WEIGHT_BITS = pwrs_pkg::WEIGHT_BITS_D,
	parameter int RANDOM_BITS = pwrs_pkg::RANDOM_BITS_D
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pwrs_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [pwrs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      kind,
	input  logic                            has_tag,
	input  logic [pwrs_pkg::PRIO_W-1:0]     priority_req,
	input  logic [pwrs_pkg::HANDLE_W-1:0]   packet_handle,
	input  logic [pwrs_pkg::BYTES_W-1:0]    packet_bytes,
	input  logic [RANDOM_BITS-1:0]          random_fraction,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      status,
	output logic [pwrs_pkg::HANDLE_W-1:0]   out_handle,
	output logic [pwrs_pkg::BYTES_W-1:0]    out_bytes,
	output logic [1:0]                      served_queue,
	output logic [pwrs_pkg::AHEAD_W-1:0]    bytes_ahead
);
	import pwrs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pwrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pwrs_dp #(
		.MAX_QUEUES (MAX_QUEUES),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.WEIGHT_BITS(WEIGHT_BITS),
		.RANDOM_BITS(RANDOM_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.kind           (kind),
		.has_tag        (has_tag),
		.priority_req   (priority_req),
		.packet_handle  (packet_handle),
		.packet_bytes   (packet_bytes),
		.random_fraction(random_fraction),
		.status         (status),
		.out_handle     (out_handle),
		.out_bytes      (out_bytes),
		.served_queue   (served_queue),
		.bytes_ahead    (bytes_ahead)
	);

	// never accept while a result is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");

	// an accepted item yields a result after EXEC, or after EXEC and READ for a pop
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> ##1 (out_valid || $past(cmd.commit) && sts.need_read))
		else $error("result latency");

	// a drop or empty status never carries a descriptor
	a_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (out_handle == '0 && out_bytes == '0))
		else $error("descriptor on failed op");
endmodule

// File: src/pwrs_ram.sv
`timescale 1ns / 1ps
module pwrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: src/pwrs_ctrl.sv
`timescale 1ns / 1ps
module pwrs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  pwrs_pkg::sts_t sts,
	output pwrs_pkg::cmd_t cmd
);
	import pwrs_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.commit = 1'b1;
				state_nx   = sts.need_read ? S_READ : S_OUT;
			end
			S_READ: begin
				cmd.capture = 1'b1;
				state_nx    = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.out_take = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end
endmodule

// File: src/pwrs_dp.sv
`timescale 1ns / 1ps
module pwrs_dp #(
	parameter int MAX_QUEUES  = pwrs_pkg::MAX_QUEUES_D,
	parameter int QUEUE_DEPTH = pwrs_pkg::QUEUE_DEPTH_D,
	parameter int WEIGHT_BITS = pwrs_pkg::WEIGHT_BITS_D,
	parameter int RANDOM_BITS = pwrs_pkg::RANDOM_BITS_D
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pwrs_pkg::cmd_t                  cmd,
	output pwrs_pkg::sts_t                  sts,
	input  logic                            cfg_we,
	input  logic [pwrs_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [pwrs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic [1:0]                      kind,
	input  logic                            has_tag,
	input  logic [pwrs_pkg::PRIO_W-1:0]     priority_req,
	input  logic [pwrs_pkg::HANDLE_W-1:0]   packet_handle,
	input  logic [pwrs_pkg::BYTES_W-1:0]    packet_bytes,
	input  logic [RANDOM_BITS-1:0]          random_fraction,
	output logic [1:0]                      status,
	output logic [pwrs_pkg::HANDLE_W-1:0]   out_handle,
	output logic [pwrs_pkg::BYTES_W-1:0]    out_bytes,
	output logic [1:0]                      served_queue,
	output logic [pwrs_pkg::AHEAD_W-1:0]    bytes_ahead
);
	import pwrs_pkg::*;

	localparam int QW   = $clog2(MAX_QUEUES);
	localparam int PW   = $clog2(QUEUE_DEPTH);
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int BCW  = CW + BYTES_W;
	localparam int TW   = WEIGHT_BITS + QW;
	localparam int AW   = QW + PW;
	localparam int SUMW = BCW + QW;

	logic [PW-1:0]  head_q  [MAX_QUEUES];
	logic [PW-1:0]  tail_q  [MAX_QUEUES];
	logic [CW-1:0]  count_q [MAX_QUEUES];
	logic [BCW-1:0] bytes_q [MAX_QUEUES];
	logic [WEIGHT_BITS-1:0] weight_q [MAX_QUEUES];
	logic [NQ_W-1:0] num_queues_q;

	// clamped live queue count
	logic [NQ_W:0] n_live;
	always_comb begin
		if (num_queues_q == '0) begin
			n_live = (NQ_W+1)'(1);
		end else if ({1'b0, num_queues_q} > (NQ_W+1)'(MAX_QUEUES)) begin
			n_live = (NQ_W+1)'(MAX_QUEUES);
		end else begin
			n_live = {1'b0, num_queues_q};
		end
	end

	logic any_busy;
	always_comb begin
		any_busy = 1'b0;
		for (int q = 0; q < MAX_QUEUES; q++) begin
			if (count_q[q] != '0) any_busy = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_queues_q <= NQ_W'(3);
			for (int q = 0; q < MAX_QUEUES; q++) weight_q[q] <= '0;
			weight_q[1] <= WEIGHT_BITS'(179);
			if (MAX_QUEUES > 2) weight_q[2 % MAX_QUEUES] <= WEIGHT_BITS'(77);
		end else if (cfg_we) begin
			if (cfg_addr == CFG_NUM_QUEUES) begin
				if (!any_busy) num_queues_q <= cfg_wdata[NQ_W-1:0];
			end else begin
				for (int q = 1; q < MAX_QUEUES && q <= 3; q++) begin
					if (cfg_addr == CFG_IDX_W'(q)) weight_q[q] <= WEIGHT_BITS'(cfg_wdata);
				end
			end
		end
	end

	// ---- decision, from the raw inputs during load ----
	logic [QW-1:0] enq_t;
	always_comb begin
		if (!has_tag) begin
			enq_t = '0;
		end else if ({{(PRIO_W-NQ_W-1){1'b0}}, n_live} <= priority_req) begin
			enq_t = QW'(n_live - 1'b1);
		end else begin
			enq_t = priority_req[QW-1:0];
		end
	end

	// weighted pick: at most MAX_QUEUES-1 narrow dependent steps
	logic [TW-1:0] total_w;
	logic [TW-1:0] cum_w;
	logic [QW-1:0] pick;
	logic          pick_ok, done;
	logic [RANDOM_BITS+TW-1:0] lhs;
	always_comb begin
		total_w = '0;
		for (int q = 1; q < MAX_QUEUES; q++) begin
			if (q < n_live && count_q[q] != '0) total_w = total_w + TW'(weight_q[q]);
		end
		lhs     = (RANDOM_BITS+TW)'(random_fraction) * (RANDOM_BITS+TW)'(total_w);
		cum_w   = '0;
		pick    = '0;
		pick_ok = 1'b0;
		done    = 1'b0;
		for (int q = 1; q < MAX_QUEUES; q++) begin
			if (!done && q < n_live && count_q[q] != '0) begin
				cum_w   = cum_w + TW'(weight_q[q]);
				pick    = QW'(q);
				pick_ok = 1'b1;
				if (lhs < {cum_w, {RANDOM_BITS{1'b0}}}) done = 1'b1;
			end
		end
	end

	// query sum
	logic [QW-1:0]    q_last;
	logic [SUMW-1:0]  qsum;
	always_comb begin
		if ({{(PRIO_W-NQ_W-1){1'b0}}, n_live} <= priority_req) begin
			q_last = QW'(MAX_QUEUES - 1);
		end else begin
			q_last = priority_req[QW-1:0];
		end
		qsum = '0;
		for (int q = 0; q < MAX_QUEUES; q++) begin
			if (QW'(q) <= q_last) qsum = qsum + SUMW'(bytes_q[q]);
		end
	end

	logic [QW-1:0] tq_d;
	logic          full_d, pop_d, empty_d;
	always_comb begin
		tq_d    = '0;
		full_d  = 1'b0;
		pop_d   = 1'b0;
		empty_d = 1'b0;
		unique case (kind_t'(kind))
			KIND_ENQ: begin
				tq_d   = enq_t;
				full_d = count_q[enq_t] >= CW'(QUEUE_DEPTH);
			end
			KIND_DEQ: begin
				if (count_q[0] != '0) begin
					pop_d = 1'b1;
				end else if (pick_ok) begin
					pop_d = 1'b1;
					tq_d  = pick;
				end else begin
					empty_d = 1'b1;
				end
			end
			KIND_QUERY, KIND_NONE: ;
			default: ;
		endcase
	end

	// ---- latched decision ----
	kind_t          kind_s1;
	logic [QW-1:0]  tq_s1;
	logic           full_s1, pop_s1, empty_s1;
	logic [DESC_W-1:0] desc_s1;
	logic [AHEAD_W-1:0] ahead_s1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_s1  <= kind_t'(kind);
			desc_s1  <= {packet_handle, packet_bytes};
			ahead_s1 <= (qsum > SUMW'(AHEAD_MAX)) ? AHEAD_MAX : AHEAD_W'(qsum);
			full_s1  <= full_d;
			pop_s1   <= pop_d;
			empty_s1 <= empty_d;
			tq_s1    <= tq_d;
		end
	end

	assign sts.need_read = pop_s1;

	// ---- descriptor memory ----
	logic enq_go;
	logic [DESC_W-1:0] rdata;
	assign enq_go = cmd.commit && kind_s1 == KIND_ENQ && !full_s1;

	// each queue owns a power-of-two slot range
	pwrs_ram #(.WIDTH(DESC_W), .DEPTH(MAX_QUEUES * (1 << PW))) u_ram (
		.clk   (clk),
		.we    (enq_go),
		.waddr (AW'({tq_s1, tail_q[tq_s1]})),
		.wdata (desc_s1),
		.raddr (AW'({tq_s1, head_q[tq_s1]})),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < MAX_QUEUES; q++) begin
				head_q[q]  <= '0;
				tail_q[q]  <= '0;
				count_q[q] <= '0;
				bytes_q[q] <= '0;
			end
		end else if (enq_go) begin
			tail_q[tq_s1]  <= (tail_q[tq_s1] == PW'(QUEUE_DEPTH - 1)) ? '0
				: tail_q[tq_s1] + 1'b1;
			count_q[tq_s1] <= count_q[tq_s1] + 1'b1;
			bytes_q[tq_s1] <= bytes_q[tq_s1] + BCW'(desc_s1[BYTES_W-1:0]);
		end else if (cmd.capture) begin
			head_q[tq_s1]  <= (head_q[tq_s1] == PW'(QUEUE_DEPTH - 1)) ? '0
				: head_q[tq_s1] + 1'b1;
			count_q[tq_s1] <= count_q[tq_s1] - 1'b1;
			bytes_q[tq_s1] <= bytes_q[tq_s1] - BCW'(rdata[BYTES_W-1:0]);
		end
	end

	// ---- result register ----
	status_t            status_d;
	logic [1:0]         served_d;
	logic [AHEAD_W-1:0] ahead_d;
	always_comb begin
		status_d = ST_OK;
		served_d = '0;
		ahead_d  = '0;
		unique case (kind_s1)
			KIND_ENQ: begin
				served_d = 2'(tq_s1);
				if (full_s1) status_d = ST_DROP;
			end
			KIND_DEQ: if (empty_s1) status_d = ST_EMPTY;
			KIND_QUERY: ahead_d = ahead_s1;
			KIND_NONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status       <= status_d;
			out_handle   <= '0;
			out_bytes    <= '0;
			served_queue <= served_d;
			bytes_ahead  <= ahead_d;
		end else if (cmd.capture) begin
			out_handle   <= rdata[DESC_W-1:BYTES_W];
			out_bytes    <= rdata[BYTES_W-1:0];
			served_queue <= 2'(tq_s1);
		end
	end
endmodule
